// ===== design/sparse_matvec_accumulate_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SPARSE_MATVEC_ACCUMULATE_ASSERT_SVH
`define SPARSE_MATVEC_ACCUMULATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SMVA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smva assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SMVA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smva assertion failed");

`endif

// ===== design/smva_pkg.sv =====
`timescale 1ns / 1ps
package smva_pkg;

  // Sizes of the vector store and of the row counter.
  localparam int VEC_DEPTH = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int ADDR_W    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Fixed field widths.
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 10;
  localparam int IDX_SUM_W  = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int ROWIDX_W   = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Product and accumulation widths.
  localparam int PROD_W  = 48;
  localparam int ACC_W   = 64;
  localparam int CLAMP_W = 42;
  localparam int RES_W   = 43;
  localparam logic signed [ACC_W-1:0] SUM_CLAMP = 64'sd1 <<< 40;
  localparam logic signed [RES_W-1:0] RES_MAX   = 43'sd2147483647;
  localparam logic signed [RES_W-1:0] RES_MIN   = -43'sd2147483648;

  // Command queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_NONZERO = 2'd1,
    FUNC_EMPTY   = 2'd2
  } smva_func_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OVERWRITE = 2'd0,
    MODE_ADD       = 2'd1,
    MODE_SUB       = 2'd2
  } smva_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_VOFFSET = 2'd1,
    CFG_ROFFSET = 2'd2
  } smva_cfg_idx_t;

  // Configuration registers as seen by front and back.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  vec_offset;
    logic [IDX_W-1:0]  row_offset;
  } smva_cfg_t;

  // One classified command for the back end.
  typedef struct packed {
    logic                     store_wr;
    logic                     mac;
    logic                     close;
    logic                     oob;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prior;
  } smva_cmd_t;

endpackage

// ===== design/smva_ram.sv =====
`timescale 1ns / 1ps
module smva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   rd_en,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Single port: write and registered read share one address; the read holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

// ===== design/smva_front.sv =====
`timescale 1ns / 1ps
module smva_front (
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [smva_pkg::FUNC_W-1:0]        in_func,
  input  logic [smva_pkg::IDX_W-1:0]         in_index,
  input  logic signed [smva_pkg::DATA_W-1:0] in_value,
  input  logic                               in_row_end,
  input  logic signed [smva_pkg::DATA_W-1:0] in_prior_value,
  input  smva_pkg::smva_cfg_t                cfg,
  input  logic                               q_full,
  output logic                               q_push,
  output smva_pkg::smva_cmd_t                q_cmd
);
  import smva_pkg::*;

  logic [IDX_SUM_W-1:0] col_addr;
  logic                 col_in_range;
  logic                 load_in_range;
  logic                 useful;

  // Column address with the vector offset applied, and range checks.
  assign col_addr      = IDX_SUM_W'(cfg.vec_offset) + IDX_SUM_W'(in_index);
  assign col_in_range  = 32'(col_addr) < VEC_DEPTH;
  assign load_in_range = 32'(in_index) < VEC_DEPTH;

  // Classify the request into a back-end command.
  always_comb begin
    q_cmd       = '0;
    q_cmd.value = in_value;
    q_cmd.prior = in_prior_value;
    useful      = 1'b0;
    unique case (smva_func_t'(in_func))
      FUNC_LOAD: begin
        q_cmd.store_wr = load_in_range;
        q_cmd.addr     = ADDR_W'(in_index);
        useful         = load_in_range;
      end
      FUNC_NONZERO: begin
        q_cmd.mac   = col_in_range;
        q_cmd.oob   = !col_in_range;
        q_cmd.close = in_row_end;
        q_cmd.addr  = ADDR_W'(col_addr);
        useful      = 1'b1;
      end
      FUNC_EMPTY: begin
        q_cmd.close = 1'b1;
        useful      = 1'b1;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  // Requests that do nothing are taken and dropped.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && useful;

endmodule

// ===== design/smva_fifo.sv =====
`timescale 1ns / 1ps
module smva_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  smva_pkg::smva_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output smva_pkg::smva_cmd_t pop_cmd
);
  import smva_pkg::*;

  smva_cmd_t             q_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full      = count_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = q_r[rd_ptr_r];

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== design/smva_back.sv =====
`timescale 1ns / 1ps
module smva_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smva_pkg::smva_cfg_t                  cfg,
  input  logic                                 q_not_empty,
  input  smva_pkg::smva_cmd_t                  q_cmd,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [smva_pkg::ROWIDX_W-1:0]        out_row_index,
  output logic signed [smva_pkg::DATA_W-1:0]   out_row_value,
  output logic                                 out_saturated,
  output logic                                 out_index_error
);
  import smva_pkg::*;

  logic advance;

  // Store read stage.
  logic                     s1_valid_r;
  logic                     s1_mac_r;
  logic                     s1_close_r;
  logic                     s1_oob_r;
  logic signed [DATA_W-1:0] s1_value_r;
  logic signed [DATA_W-1:0] s1_prior_r;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [ACC_W-1:0]  s1_prod_full;

  // Product stage.
  logic                     s2_valid_r;
  logic                     s2_close_r;
  logic                     s2_oob_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [DATA_W-1:0] s2_prior_r;

  // Accumulator and row state.
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     row_err_r;
  logic [ROW_W-1:0]         row_cnt_r;
  logic [ROW_W-1:0]         row_cnt_nxt;
  logic                     s2_closing;

  // Row close stages.
  logic                     s3_valid_r;
  logic signed [ACC_W-1:0]  s3_sum_r;
  logic signed [DATA_W-1:0] s3_prior_r;
  logic                     s3_err_r;
  logic [ROWIDX_W-1:0]      s3_row_r;
  logic signed [CLAMP_W-1:0] s3_clamped;

  logic                      s4_valid_r;
  logic signed [CLAMP_W-1:0] s4_sum_r;
  logic signed [DATA_W-1:0]  s4_prior_r;
  logic                      s4_err_r;
  logic [ROWIDX_W-1:0]       s4_row_r;
  logic signed [RES_W-1:0]   s4_result;

  logic out_valid_r;

  // The whole back pipeline moves together unless a result is stuck.
  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && q_not_empty;

  // Vector store: loads write, nonzeros read.
  smva_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VEC_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (q_pop && q_cmd.store_wr),
    .addr  (q_cmd.addr),
    .wdata (q_cmd.value),
    .rd_en (advance),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mac_r   <= q_cmd.mac;
      s1_close_r <= q_cmd.close;
      s1_oob_r   <= q_cmd.oob;
      s1_value_r <= q_cmd.value;
      s1_prior_r <= q_cmd.prior;
    end
  end

  // Multiply; the shift rounds toward minus infinity.
  assign s1_prod_full = s1_value_r * $signed(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod_r  <= s1_mac_r ? PROD_W'(s1_prod_full >>> 16) : '0;
      s2_close_r <= s1_close_r;
      s2_oob_r   <= s1_oob_r;
      s2_prior_r <= s1_prior_r;
    end
  end

  // Accumulate and close the row.
  assign acc_sum     = acc_r + ACC_W'(s2_prod_r);
  assign s2_closing  = s2_valid_r && s2_close_r;
  assign row_cnt_nxt = (row_cnt_r == ROW_W'(MAX_ROWS - 1)) ? '0 : row_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      row_err_r  <= 1'b0;
      row_cnt_r  <= '0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_closing;
      if (s2_valid_r) begin
        if (s2_close_r) begin
          acc_r     <= '0;
          row_err_r <= 1'b0;
          row_cnt_r <= row_cnt_nxt;
        end else begin
          acc_r     <= acc_sum;
          row_err_r <= row_err_r || s2_oob_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sum_r   <= acc_sum;
      s3_prior_r <= s2_prior_r;
      s3_err_r   <= row_err_r || s2_oob_r;
      s3_row_r   <= ROWIDX_W'(row_cnt_r) + ROWIDX_W'(cfg.row_offset);
    end
  end

  // Clamp the row sum before combining it with the prior value.
  always_comb begin
    if (s3_sum_r > SUM_CLAMP) begin
      s3_clamped = CLAMP_W'(SUM_CLAMP);
    end else if (s3_sum_r < -SUM_CLAMP) begin
      s3_clamped = CLAMP_W'(-SUM_CLAMP);
    end else begin
      s3_clamped = CLAMP_W'(s3_sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (advance) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_sum_r   <= s3_clamped;
      s4_prior_r <= s3_prior_r;
      s4_err_r   <= s3_err_r;
      s4_row_r   <= s3_row_r;
    end
  end

  // Apply the mode; the unused code acts as overwrite.
  always_comb begin
    case (cfg.mode)
      MODE_ADD: s4_result = RES_W'(s4_prior_r) + RES_W'(s4_sum_r);
      MODE_SUB: s4_result = RES_W'(s4_prior_r) - RES_W'(s4_sum_r);
      default:  s4_result = RES_W'(s4_sum_r);
    endcase
  end

  // Output register with saturation to 32 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row_index   <= s4_row_r;
      out_index_error <= s4_err_r;
      if (s4_result > RES_MAX) begin
        out_row_value <= DATA_W'(RES_MAX);
        out_saturated <= 1'b1;
      end else if (s4_result < RES_MIN) begin
        out_row_value <= DATA_W'(RES_MIN);
        out_saturated <= 1'b1;
      end else begin
        out_row_value <= DATA_W'(s4_result);
        out_saturated <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/sparse_matvec_accumulate.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Carries
// in_     | input     | in_valid/in_ready   | func, index, value, row_end, prior_value
// out_    | output    | out_valid/out_ready | row_index, row_value, saturated, index_error
// cfg_    | input     | cfg_valid/cfg_ready | register index, write data
//
// One request is taken every cycle while the queue is not full.
// The single-port vector store and one 32x32 multiplier per cycle set that rate.
// Reset is synchronous and clears control state only; the vector store is not cleared.
// When a result waits with out_ready low the back pipeline holds; the four-entry queue keeps taking
// requests until it fills, then in_ready falls.
module sparse_matvec_accumulate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smva_pkg::FUNC_W-1:0]          in_func,
  input  logic [smva_pkg::IDX_W-1:0]           in_index,
  input  logic signed [smva_pkg::DATA_W-1:0]   in_value,
  input  logic                                 in_row_end,
  input  logic signed [smva_pkg::DATA_W-1:0]   in_prior_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [smva_pkg::ROWIDX_W-1:0]        out_row_index,
  output logic signed [smva_pkg::DATA_W-1:0]   out_row_value,
  output logic                                 out_saturated,
  output logic                                 out_index_error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smva_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smva_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import smva_pkg::*;

  smva_cfg_t cfg_r;
  logic      q_full;
  logic      q_push;
  smva_cmd_t q_push_cmd;
  logic      q_pop;
  logic      q_not_empty;
  smva_cmd_t q_pop_cmd;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (smva_cfg_idx_t'(cfg_index))
        CFG_MODE:    cfg_r.mode       <= MODE_W'(cfg_data);
        CFG_VOFFSET: cfg_r.vec_offset <= IDX_W'(cfg_data);
        CFG_ROFFSET: cfg_r.row_offset <= IDX_W'(cfg_data);
        default:     cfg_r            <= cfg_r;
      endcase
    end
  end

  smva_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_row_end     (in_row_end),
    .in_prior_value (in_prior_value),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd)
  );

  smva_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_pop_cmd)
  );

  smva_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_cmd           (q_pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_index   (out_row_index),
    .out_row_value   (out_row_value),
    .out_saturated   (out_saturated),
    .out_index_error (out_index_error)
  );

endmodule

// ===== design/smva_checker.sv =====
`timescale 1ns / 1ps
`include "sparse_matvec_accumulate_assert.svh"
module smva_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [smva_pkg::ROWIDX_W-1:0]      out_row_index,
  input logic signed [smva_pkg::DATA_W-1:0] out_row_value,
  input logic                               out_saturated,
  input logic                               out_index_error
);

  // A stalled result keeps its contents.
  `SMVA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row_value) && $stable(out_row_index) && $stable(out_saturated) && $stable(out_index_error))

  // A stalled request is not withdrawn.
  `SMVA_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

  // A clipped result sits at one of the two 32-bit limits.
  `SMVA_ASSERT_NOW(a_sat_limit, out_valid && out_saturated, (out_row_value == 32'sh7fffffff) || (out_row_value == 32'sh80000000))

  // Right after reset nothing is pending and requests are taken.
  `SMVA_ASSERT_NOW(a_reset_clean, $past(!rst_n), !out_valid && in_ready)

endmodule

bind sparse_matvec_accumulate smva_checker u_smva_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_row_index   (out_row_index),
  .out_row_value   (out_row_value),
  .out_saturated   (out_saturated),
  .out_index_error (out_index_error)
);
